[design/assert_macros.svh]
// Assertion macros used by the checker file of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define CCT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Concurrent assertion on the local clk and rst.
`define CCT_ASSERT_CLK(lbl, prop, msg) `CCT_ASSERT(lbl, clk, rst, prop, msg)

`endif

[design/cct_pkg.sv]
// Package with the types and constants of the character class tokenizer.
`default_nettype none
package cct_pkg;

  // Default maximum token length.
  localparam int MAX_TOKEN_LEN_DEF = 32;

  // Mode register codes.
  localparam logic [1:0] MODE_SPACE  = 2'd0;
  localparam logic [1:0] MODE_LETTER = 2'd1;
  localparam logic [1:0] MODE_LOWER  = 2'd2;

  // Input item operation codes.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0]  out_char;
    logic [31:0] token_start;
    logic [31:0] token_end;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_req;
    logic emit_last;
    logic out_free;
  } status_t;

  // C locale space test.
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // ASCII letter test.
  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage
`default_nettype wire

[design/cct_ctrl.sv]
// Controller state machine: accepts characters and sequences token emission.
`default_nettype none
module cct_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire cct_pkg::status_t status,
  output cct_pkg::cmd_t        cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  // Input is blocked while a token is read out.
  assign item_stall = (state == ST_EMIT);
  assign cmd.accept = item_valid && (state == ST_IDLE);
  assign cmd.load   = (state == ST_EMIT) && status.out_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && status.emit_req) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.load && status.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[design/cct_dp.sv]
// Datapath: classification, token buffer, offsets and the result register.
`default_nettype none
module cct_dp #(
  parameter int MAX_TOKEN_LEN = cct_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cct_pkg::item_t   item,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_wdata,
  input  wire cct_pkg::cmd_t    cmd,
  output cct_pkg::status_t      status,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output cct_pkg::result_t      res
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int IDX_W = $clog2(MAX_TOKEN_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  logic [1:0]       mode;
  logic [LEN_W-1:0] token_len;
  logic [31:0]      char_offset;
  logic [31:0]      start_offset;
  logic [7:0]       tok_mem [MAX_TOKEN_LEN];

  logic [LEN_W-1:0] emit_len;
  logic [31:0]      emit_start;
  logic [IDX_W-1:0] rd_idx;

  logic             member;
  logic [7:0]       norm_ch;
  logic [LEN_W-1:0] len_inc;
  logic [LEN_W-1:0] len_next;
  logic [31:0]      start_next;
  logic [LEN_W-1:0] cnt_next;
  logic             emit_req;

  // Classify and normalize the incoming character.
  always_comb begin
    member  = (mode == cct_pkg::MODE_SPACE) ? !cct_pkg::is_space(item.ch)
                                            : cct_pkg::is_letter(item.ch);
    norm_ch = item.ch;
    if (mode >= cct_pkg::MODE_LOWER && item.ch >= 8'h41 && item.ch <= 8'h5A) begin
      norm_ch = item.ch + 8'h20;
    end
    len_inc = token_len + LEN_W'(1);
  end

  // Decide whether this transaction emits a token, and the updated length.
  always_comb begin
    emit_req   = 1'b0;
    len_next   = '0;
    cnt_next   = token_len;
    start_next = start_offset;
    if (item.op == cct_pkg::OP_EOS) begin
      emit_req   = (token_len != '0);
      start_next = '0;
    end else if (member) begin
      if (token_len == '0) start_next = char_offset;
      cnt_next = len_inc;
      if (len_inc == LEN_MAX) begin
        emit_req = 1'b1;
      end else begin
        len_next = len_inc;
      end
    end else begin
      emit_req = (token_len != '0);
    end
  end

  assign status.emit_req  = emit_req;
  assign status.emit_last = ((LEN_W'(rd_idx) + LEN_W'(1)) == emit_len);
  assign status.out_free  = !res_valid || !res_stall;

  // Mode register and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= cct_pkg::MODE_SPACE;
      token_len    <= '0;
      char_offset  <= '0;
      start_offset <= '0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (cmd.accept) begin
        token_len    <= len_next;
        start_offset <= start_next;
        char_offset  <= (item.op == cct_pkg::OP_EOS) ? 32'd0 : char_offset + 32'd1;
      end
    end
  end

  // Token buffer write.
  always_ff @(posedge clk) begin
    if (cmd.accept && item.op == cct_pkg::OP_CHAR && member) begin
      tok_mem[token_len[IDX_W-1:0]] <= norm_ch;
    end
  end

  // Capture the token being emitted and step through its characters.
  always_ff @(posedge clk) begin
    if (cmd.accept && emit_req) begin
      emit_len   <= cnt_next;
      emit_start <= (item.op == cct_pkg::OP_CHAR && member && token_len == '0)
                    ? char_offset : start_offset;
      rd_idx     <= '0;
    end else if (cmd.load) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // Result register, loaded straight from the token buffer read.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res.out_char    <= tok_mem[rd_idx];
      res.token_start <= emit_start;
      res.token_end   <= emit_start + 32'(emit_len);
      res.last        <= status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[design/char_class_tokenizer.sv]
// Top level of the character class tokenizer.
//
// Input channel (item_valid, item_stall, item): one character or an end of
// stream marker per transaction. Result channel (res_valid, res_stall, res):
// one token character per transaction, with start and end offsets and a
// last flag on the token's final character. cfg_we/cfg_wdata write the mode.
//
// Plain text, whose characters emit nothing, flows at one character per
// cycle while no token is read out. A transaction that closes a token holds
// item_stall high while the token buffer is read out one entry per cycle,
// unless the result channel stalls, into the result register; the single
// read port of the token buffer sets that rate. The controller first enters
// its emit state, then loads the first character. Input is accepted again
// while the final result still waits in the result register.
//
// Reset (rst, synchronous) clears the mode, offsets, token length and the
// result valid flag. A stalled result holds its value; read-out pauses
// until the receiver takes it.
`default_nettype none
module char_class_tokenizer #(
  parameter int MAX_TOKEN_LEN = cct_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire cct_pkg::item_t   item,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output cct_pkg::result_t      res,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_wdata
);

  cct_pkg::cmd_t    cmd;
  cct_pkg::status_t status;

  cct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  cct_dp #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

[design/cct_checker.sv]
// Port level checker for the tokenizer and its bind.
`default_nettype none
`include "assert_macros.svh"
module cct_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_stall,
  input wire logic             res_valid,
  input wire logic             res_stall,
  input wire cct_pkg::result_t res
);

  // A stalled result stays offered.
  `CCT_ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid, "result dropped")

  // A transaction inside a token is followed at once by the next character.
  `CCT_ASSERT_CLK(a_no_gap, res_valid && !res_stall && !res.last |=> res_valid, "gap in token")

  // Input stays blocked while a token is still being read out.
  `CCT_ASSERT_CLK(a_block_in, res_valid && !res.last |-> item_stall, "input during token")

  // Every token has at least one character.
  `CCT_ASSERT_CLK(a_len, res_valid |-> res.token_end != res.token_start, "empty token")

endmodule

bind char_class_tokenizer cct_checker u_cct_checker (
  .clk        (clk),
  .rst        (rst),
  .item_stall (item_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res)
);
`default_nettype wire
